FILE: rtl/core/wtsc_pkg.sv
package wtsc_pkg;

  localparam int unsigned WTSC_WAVE_BYTES = 16;

  typedef enum logic [2:0] {
    ACT_REG_WR  = 3'd0,
    ACT_REG_RD  = 3'd1,
    ACT_RAM_WR  = 3'd2,
    ACT_RAM_RD  = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_LEN_CLK = 3'd5,
    ACT_DISABLE = 3'd6
  } action_t;

  localparam logic [3:0] REG_DAC    = 4'd0;
  localparam logic [3:0] REG_LENGTH = 4'd1;
  localparam logic [3:0] REG_VOLUME = 4'd2;
  localparam logic [3:0] REG_PER_LO = 4'd3;
  localparam logic [3:0] REG_PER_HI = 4'd4;

  localparam logic [7:0] MASK_DAC    = 8'h7F;
  localparam logic [7:0] MASK_LENGTH = 8'hFF;
  localparam logic [7:0] MASK_VOLUME = 8'h9F;
  localparam logic [7:0] MASK_PER_LO = 8'hFF;
  localparam logic [7:0] MASK_PER_HI = 8'hBF;
  localparam logic [7:0] MASK_NONE   = 8'hFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  address;
    logic [7:0]  write_data;
    logic [12:0] tick_clocks;
  } item_t;

  function automatic logic [15:0] reload_value(input logic [10:0] period);
    logic [11:0] span;
    span = 12'd2048 - {1'b0, period};
    return {3'b000, span, 1'b0};
  endfunction

endpackage

FILE: rtl/core/wtsc_in_stage.sv
module wtsc_in_stage
  import wtsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_address,
  input  logic [7:0]  in_write_data,
  input  logic [12:0] in_tick_clocks,
  input  logic        take,
  output logic        item_valid,
  output item_t       item
);

  logic  item_valid_r;
  item_t item_r;

  assign in_ready   = !item_valid_r || take;
  assign item_valid = item_valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action      <= in_action;
      item_r.address     <= in_address;
      item_r.write_data  <= in_write_data;
      item_r.tick_clocks <= in_tick_clocks;
    end
  end

endmodule

FILE: rtl/core/wtsc_core.sv
module wtsc_core
  import wtsc_pkg::*;
#(
  parameter int unsigned WAVE_BYTES = WTSC_WAVE_BYTES
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  item_t      item,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [3:0] out_sample_out,
  output logic       out_channel_on
);

  localparam int unsigned RAM_AW = $clog2(WAVE_BYTES);

  logic [7:0]            ram_mem [WAVE_BYTES];
  logic [WAVE_BYTES-1:0] ram_vld_r;

  logic        dac_on_r,     dac_on_nxt;
  logic [3:0]  sample_r,     sample_nxt;
  logic [4:0]  pos_r,        pos_nxt;
  logic [1:0]  volume_r,     volume_nxt;
  logic [10:0] period_r,     period_nxt;
  logic [8:0]  length_r,     length_nxt;
  logic        length_on_r,  length_on_nxt;
  logic        playing_r,    playing_nxt;
  logic [15:0] timer_r,      timer_nxt;
  logic [3:0]  level_r,      level_nxt;
  logic        out_valid_r;
  logic [7:0]  read_data_r,  read_data_nxt;

  logic              ram_we;
  logic              ram_rd;
  logic              fetch;
  logic [15:0]       timer_dec;
  logic [RAM_AW-1:0] acc_idx;
  logic [RAM_AW-1:0] fetch_idx;

  assign take           = item_valid && (!out_valid_r || out_ready);
  assign out_valid      = out_valid_r;
  assign out_read_data  = read_data_r;
  assign out_sample_out = level_r;
  assign out_channel_on = playing_r;

  assign acc_idx   = item.address[RAM_AW-1:0];
  assign timer_dec = timer_r - {3'b000, item.tick_clocks};

  always_comb begin
    dac_on_nxt    = dac_on_r;
    sample_nxt    = sample_r;
    pos_nxt       = pos_r;
    volume_nxt    = volume_r;
    period_nxt    = period_r;
    length_nxt    = length_r;
    length_on_nxt = length_on_r;
    playing_nxt   = playing_r;
    timer_nxt     = timer_r;
    level_nxt     = level_r;
    read_data_nxt = 8'h00;
    ram_we        = 1'b0;
    ram_rd        = 1'b0;
    fetch         = 1'b0;
    case (action_t'(item.action))
      ACT_REG_WR: begin
        case (item.address)
          REG_DAC: begin
            dac_on_nxt  = item.write_data[7];
            playing_nxt = playing_r & item.write_data[7];
          end
          REG_LENGTH: begin
            length_nxt = 9'd256 - {1'b0, item.write_data};
          end
          REG_VOLUME: begin
            volume_nxt = item.write_data[6:5];
          end
          REG_PER_LO: begin
            period_nxt = {period_r[10:8], item.write_data};
          end
          REG_PER_HI: begin
            period_nxt    = {item.write_data[2:0], period_r[7:0]};
            length_on_nxt = item.write_data[6];
            if (item.write_data[7]) begin
              playing_nxt = dac_on_r;
              timer_nxt   = reload_value(period_nxt);
              pos_nxt     = 5'd0;
              if (length_r == 9'd0) begin
                length_nxt = 9'd256;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_REG_RD: begin
        case (item.address)
          REG_DAC:    read_data_nxt = {dac_on_r, 7'd0} | MASK_DAC;
          REG_LENGTH: read_data_nxt = MASK_LENGTH;
          REG_VOLUME: read_data_nxt = {1'b0, volume_r, 5'd0} | MASK_VOLUME;
          REG_PER_LO: read_data_nxt = MASK_PER_LO;
          REG_PER_HI: read_data_nxt = {1'b0, length_on_r, 6'd0} | MASK_PER_HI;
          default:    read_data_nxt = MASK_NONE;
        endcase
      end
      ACT_RAM_WR: ram_we = 1'b1;
      ACT_RAM_RD: ram_rd = 1'b1;
      ACT_TICK: begin
        if (volume_r != 2'd0 && playing_r) begin
          level_nxt = sample_r >> (volume_r - 2'd1);
        end else begin
          level_nxt = 4'd0;
        end
        if (timer_dec == 16'd0) begin
          timer_nxt = reload_value(period_r);
          pos_nxt   = pos_r + 5'd1;
          fetch     = 1'b1;
        end else begin
          timer_nxt = timer_dec;
        end
      end
      ACT_LEN_CLK: begin
        if (length_on_r && length_r != 9'd0) begin
          length_nxt = length_r - 9'd1;
          if (length_r == 9'd1) begin
            playing_nxt = 1'b0;
          end
        end
      end
      ACT_DISABLE: begin
        dac_on_nxt    = 1'b0;
        sample_nxt    = 4'd0;
        pos_nxt       = 5'd0;
        volume_nxt    = 2'd0;
        period_nxt    = 11'd0;
        length_on_nxt = 1'b0;
        playing_nxt   = 1'b0;
        timer_nxt     = 16'd0;
        level_nxt     = 4'd0;
      end
      default: ;
    endcase
  end

  assign fetch_idx = RAM_AW'(pos_nxt[4:1]);

  always_ff @(posedge clk) begin
    if (take && ram_we) begin
      ram_mem[acc_idx] <= item.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (ram_rd) begin
        read_data_r <= ram_vld_r[acc_idx] ? ram_mem[acc_idx] : 8'h00;
      end else begin
        read_data_r <= read_data_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_vld_r   <= '0;
      dac_on_r    <= 1'b0;
      sample_r    <= 4'd0;
      pos_r       <= 5'd0;
      volume_r    <= 2'd0;
      period_r    <= 11'd0;
      length_r    <= 9'd0;
      length_on_r <= 1'b0;
      playing_r   <= 1'b0;
      timer_r     <= 16'd0;
      level_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (ram_we) begin
          ram_vld_r[acc_idx] <= 1'b1;
        end
        dac_on_r    <= dac_on_nxt;
        pos_r       <= pos_nxt;
        volume_r    <= volume_nxt;
        period_r    <= period_nxt;
        length_r    <= length_nxt;
        length_on_r <= length_on_nxt;
        playing_r   <= playing_nxt;
        timer_r     <= timer_nxt;
        level_r     <= level_nxt;
        if (fetch) begin
          if (!ram_vld_r[fetch_idx]) begin
            sample_r <= 4'd0;
          end else if (pos_nxt[0]) begin
            sample_r <= ram_mem[fetch_idx][3:0];
          end else begin
            sample_r <= ram_mem[fetch_idx][7:4];
          end
        end else begin
          sample_r <= sample_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/wave_table_sound_channel.sv
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_ready   | action, address, write_data, tick_clocks
// out_     | output    | out_valid / out_ready | read_data, sample_out, channel_on
//
// One transaction per cycle sustained while out_ready stays high; each is registered in the input register,
// then passes the state update, then is registered in the result register.
// Synchronous reset clears the channel state, both valid flags and the wave RAM valid bits; read data is not reset.
// A stalled result register holds; one more input transaction waits in the input register.
module wave_table_sound_channel
  import wtsc_pkg::*;
#(
  parameter int unsigned WAVE_BYTES = WTSC_WAVE_BYTES
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_address,
  input  logic [7:0]  in_write_data,
  input  logic [12:0] in_tick_clocks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [3:0]  out_sample_out,
  output logic        out_channel_on
);

  logic  take;
  logic  item_valid;
  item_t item;

  wtsc_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_tick_clocks (in_tick_clocks),
    .take           (take),
    .item_valid     (item_valid),
    .item           (item)
  );

  wtsc_core #(
    .WAVE_BYTES (WAVE_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item           (item),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_sample_out (out_sample_out),
    .out_channel_on (out_channel_on)
  );

endmodule

FILE: rtl/core/wtsc_checker.sv
module wtsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [3:0]  out_sample_out,
  input logic        out_channel_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
      $stable(out_sample_out) && $stable(out_channel_on))
    else $error("result dropped or changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  a_reset_state: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_ready && !out_valid)
    else $error("handshake not idle after reset");

endmodule

bind wave_table_sound_channel wtsc_checker u_wtsc_checker (.*);
